// ===== src/bleng_pkg.sv =====
// shared types and constants of the bresenham line engine
package bleng_pkg;

  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned COLOR_BITS      = 16;
  localparam int unsigned APB_ADDR_BITS   = 3;
  localparam int unsigned APB_DATA_BITS   = 32;

  localparam logic [COLOR_BITS-1:0] COLOR_RESET = 16'hFFFF;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_e;

  // register index taken from paddr[2]
  typedef enum logic {
    REG_DRAW_COLOR = 1'b0,
    REG_NONE       = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic load;
    logic dir_down;
    logic swapped;
  } line_flags_t;

endpackage

// ===== src/bresenham_line_engine.sv =====
// top level of the bresenham line engine
//
//  channel  dir  handshake                     contents
//  s_axis   in   s_axis_tvalid/s_axis_tready   tuser cmd, tdata endpoints
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata pixel, tlast last pixel
//  apb      in   psel/penable, pready high     draw_color at address 0
//
//  one request per cycle in and one pixel per cycle out while nothing stalls, set by the
//  single subtract, compare and add of the error term in the walker
//  a step request passes the queue, and its pixel then the output register
//  reset clears the queue, the walker and the output; draw_color reads 0xffff
//  the front end stalls only on a full queue, the walker only on a held output
module bresenham_line_engine #(
  parameter int unsigned COORD_BITS  = bleng_pkg::COORD_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = bleng_pkg::QUEUE_DEPTH_DEF,
  localparam int unsigned IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * COORD_BITS + bleng_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // x_start, y_start, x_end, y_end
  input  logic [IN_W-1:0]                     s_axis_tdata,
  // cmd
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [OUT_W-1:0]                    m_axis_tdata,
  output logic                                m_axis_tlast,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bleng_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [bleng_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [bleng_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                                pready
);

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned QW = $bits(bleng_pkg::line_flags_t) + 5 * W;

  logic [bleng_pkg::COLOR_BITS-1:0] draw_color_q, draw_color_d;
  bleng_pkg::line_flags_t           push_flags, pop_flags;
  logic [5*W-1:0]                   push_payload, pop_payload;
  logic [QW-1:0]                    pop_data;
  logic                             push_valid, push_ready, pop_valid, pop_ready;
  logic [W-1:0]                     pixel_x, pixel_y;
  logic [bleng_pkg::COLOR_BITS-1:0] pixel_color;
  logic                             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (bleng_pkg::reg_idx_e'(paddr[2]) == bleng_pkg::REG_DRAW_COLOR);
  assign draw_color_d = cfg_wr ? pwdata[bleng_pkg::COLOR_BITS-1:0] : draw_color_q;
  assign prdata = (bleng_pkg::reg_idx_e'(paddr[2]) == bleng_pkg::REG_DRAW_COLOR) ?
                  bleng_pkg::APB_DATA_BITS'(draw_color_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_color_q <= bleng_pkg::COLOR_RESET;
    end else begin
      draw_color_q <= draw_color_d;
    end
  end

  bleng_front #(.COORD_BITS(W)) u_front (
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .x_start_i    (s_axis_tdata[W-1:0]),
    .y_start_i    (s_axis_tdata[2*W-1:W]),
    .x_end_i      (s_axis_tdata[3*W-1:2*W]),
    .y_end_i      (s_axis_tdata[4*W-1:3*W]),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .flags_o      (push_flags),
    .payload_o    (push_payload)
  );

  bleng_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({push_flags, push_payload}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  assign {pop_flags, pop_payload} = pop_data;

  bleng_back #(.COORD_BITS(W)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (pop_valid),
    .q_ready_o     (pop_ready),
    .flags_i       (pop_flags),
    .payload_i     (pop_payload),
    .color_i       (draw_color_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .pixel_x_o     (pixel_x),
    .pixel_y_o     (pixel_y),
    .pixel_color_o (pixel_color),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({pixel_color, pixel_y, pixel_x});

endmodule

// ===== src/bleng_front.sv =====
// front end: classifies requests and performs line setup
module bleng_front #(
  parameter int unsigned COORD_BITS = bleng_pkg::COORD_BITS_DEF
) (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [COORD_BITS-1:0]     x_start_i,
  input  logic [COORD_BITS-1:0]     y_start_i,
  input  logic [COORD_BITS-1:0]     x_end_i,
  input  logic [COORD_BITS-1:0]     y_end_i,
  output logic                      push_valid_o,
  input  logic                      push_ready_i,
  output bleng_pkg::line_flags_t    flags_o,
  output logic [5*COORD_BITS-1:0]   payload_o
);

  logic [COORD_BITS-1:0] dx, dy, a_s, a_e, b_s, b_e;
  logic [COORD_BITS-1:0] a0, a1, b0, b1, dmaj, dmin;
  logic                  steep, x_rev, y_rev, rev;

  always_comb begin
    dx    = (x_end_i > x_start_i) ? (x_end_i - x_start_i) : (x_start_i - x_end_i);
    dy    = (y_end_i > y_start_i) ? (y_end_i - y_start_i) : (y_start_i - y_end_i);
    x_rev = x_start_i > x_end_i;
    y_rev = y_start_i > y_end_i;
    steep = dy > dx;
    a_s   = steep ? y_start_i : x_start_i;
    a_e   = steep ? y_end_i   : x_end_i;
    b_s   = steep ? x_start_i : y_start_i;
    b_e   = steep ? x_end_i   : y_end_i;
    rev   = steep ? y_rev : x_rev;
    a0    = rev ? a_e : a_s;
    a1    = rev ? a_s : a_e;
    b0    = rev ? b_e : b_s;
    b1    = rev ? b_s : b_e;
    dmaj  = steep ? dy : dx;
    dmin  = steep ? dx : dy;
  end

  assign flags_o.load     = (bleng_pkg::cmd_e'(cmd_i) == bleng_pkg::CMD_LOAD);
  assign flags_o.dir_down = (b0 >= b1);
  assign flags_o.swapped  = steep;
  assign payload_o        = {a0, b0, a1, dmaj, dmin};
  assign push_valid_o     = in_valid_i;
  assign in_ready_o       = push_ready_i;

endmodule

// ===== src/bleng_queue.sv =====
// short request queue between front end and walker
module bleng_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = bleng_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW:0]      count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != DEPTH[AW:0]);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/bleng_back.sv =====
// back end: line walker with registered pixel output
module bleng_back #(
  parameter int unsigned COORD_BITS = bleng_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  output logic                             q_ready_o,
  input  bleng_pkg::line_flags_t           flags_i,
  input  logic [5*COORD_BITS-1:0]          payload_i,
  input  logic [bleng_pkg::COLOR_BITS-1:0] color_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [COORD_BITS-1:0]            pixel_x_o,
  output logic [COORD_BITS-1:0]            pixel_y_o,
  output logic [bleng_pkg::COLOR_BITS-1:0] pixel_color_o,
  output logic                             last_o
);

  localparam int unsigned W = COORD_BITS;

  logic [W-1:0] major_pos_q, major_pos_d, minor_pos_q, minor_pos_d;
  logic [W-1:0] major_end_q, major_end_d, dmaj_q, dmaj_d, dmin_q, dmin_d;
  logic signed [W:0] err_q, err_d, err_sub;
  logic dir_down_q, dir_down_d, swapped_q, swapped_d, busy_q, busy_d;
  logic out_valid_q, out_valid_d, last_q, last_d;
  logic [W-1:0] px_q, px_d, py_q, py_d;
  logic [bleng_pkg::COLOR_BITS-1:0] color_q, color_d;

  logic [W-1:0] ld_a0, ld_b0, ld_a1, ld_dmaj, ld_dmin;
  logic out_free, take, emit, is_last;

  assign {ld_a0, ld_b0, ld_a1, ld_dmaj, ld_dmin} = payload_i;

  assign out_free  = !out_valid_q || out_ready_i;
  assign take      = q_valid_i && (flags_i.load || !busy_q || out_free);
  assign emit      = take && !flags_i.load && busy_q;
  assign q_ready_o = flags_i.load || !busy_q || out_free;
  assign is_last   = (major_pos_q == major_end_q);
  assign err_sub   = err_q - $signed({1'b0, dmin_q});

  always_comb begin
    major_pos_d = major_pos_q;
    minor_pos_d = minor_pos_q;
    major_end_d = major_end_q;
    dmaj_d      = dmaj_q;
    dmin_d      = dmin_q;
    err_d       = err_q;
    dir_down_d  = dir_down_q;
    swapped_d   = swapped_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q && !out_ready_i;
    px_d        = px_q;
    py_d        = py_q;
    color_d     = color_q;
    last_d      = last_q;
    if (take && flags_i.load) begin
      major_pos_d = ld_a0;
      minor_pos_d = ld_b0;
      major_end_d = ld_a1;
      dmaj_d      = ld_dmaj;
      dmin_d      = ld_dmin;
      err_d       = $signed({2'b00, ld_dmaj[W-1:1]});
      dir_down_d  = flags_i.dir_down;
      swapped_d   = flags_i.swapped;
      busy_d      = 1'b1;
    end else if (emit) begin
      out_valid_d = 1'b1;
      px_d        = swapped_q ? minor_pos_q : major_pos_q;
      py_d        = swapped_q ? major_pos_q : minor_pos_q;
      color_d     = color_i;
      last_d      = is_last;
      if (err_sub < 0) begin
        minor_pos_d = dir_down_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
        err_d       = err_sub + $signed({1'b0, dmaj_q});
      end else begin
        err_d = err_sub;
      end
      major_pos_d = major_pos_q + 1'b1;
      busy_d      = !is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    major_pos_q <= major_pos_d;
    minor_pos_q <= minor_pos_d;
    major_end_q <= major_end_d;
    dmaj_q      <= dmaj_d;
    dmin_q      <= dmin_d;
    err_q       <= err_d;
    dir_down_q  <= dir_down_d;
    swapped_q   <= swapped_d;
    px_q        <= px_d;
    py_q        <= py_d;
    color_q     <= color_d;
    last_q      <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = color_q;
  assign last_o        = last_q;

endmodule

// ===== src/bleng_checker.sv =====
// port checker of the bresenham line engine and its bind
module bleng_checker #(
  parameter int unsigned COORD_BITS = bleng_pkg::COORD_BITS_DEF,
  localparam int unsigned OUT_W = ((2 * COORD_BITS + bleng_pkg::COLOR_BITS + 7) / 8) * 8
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [OUT_W-1:0]                    m_axis_tdata,
  input logic                                m_axis_tlast,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [bleng_pkg::APB_ADDR_BITS-1:0] paddr,
  input logic [bleng_pkg::APB_DATA_BITS-1:0] pwdata,
  input logic [bleng_pkg::APB_DATA_BITS-1:0] prdata,
  input logic                                pready
);

  logic color_wr;

  assign color_wr = psel && penable && pwrite && pready &&
                    (bleng_pkg::reg_idx_e'(paddr[2]) == bleng_pkg::REG_DRAW_COLOR);

  // a held pixel keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("pixel changed while stalled");

  // reset drops any pending pixel
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("pixel valid during reset");

  // the request side is ready right after reset, the queue being empty
  a_ready_after_reset: assert property (@(posedge clk_i) $past(!rst_ni) |-> s_axis_tready)
    else $error("request side not ready after reset");

  // colour readback follows the last write
  a_color_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    color_wr ##1 (bleng_pkg::reg_idx_e'(paddr[2]) == bleng_pkg::REG_DRAW_COLOR) |->
      prdata[bleng_pkg::COLOR_BITS-1:0] == $past(pwdata[bleng_pkg::COLOR_BITS-1:0]))
    else $error("draw colour readback mismatch");

endmodule

bind bresenham_line_engine bleng_checker #(.COORD_BITS(COORD_BITS)) u_bleng_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);

// ===== tb/tb_bresenham_line_engine.sv =====
// self-checking testbench of the bresenham line engine with its own line predictor
`timescale 1ns / 100ps

module tb_bresenham_line_engine;

  localparam int unsigned CW            = bleng_pkg::COORD_BITS_DEF;
  localparam int unsigned COLOR_W       = bleng_pkg::COLOR_BITS;
  localparam int unsigned ADDR_W        = bleng_pkg::APB_ADDR_BITS;
  localparam int unsigned DATA_W        = bleng_pkg::APB_DATA_BITS;
  localparam int unsigned IN_W          = ((4 * CW + 7) / 8) * 8;
  localparam int unsigned OUT_W         = ((2 * CW + COLOR_W + 7) / 8) * 8;
  localparam int unsigned COORD_MAX     = (1 << CW) - 1;
  localparam int unsigned RANDOM_REQS   = 1100;
  localparam int unsigned RECOLOUR_GAP  = 300;
  localparam int unsigned HOLD_CYCLES   = 80;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PRINT_LIMIT   = 50;

  localparam logic [ADDR_W-1:0] ADDR_DRAW_COLOR = {bleng_pkg::REG_DRAW_COLOR, 2'b00};

  typedef logic [CW-1:0] coord_t;

  typedef struct {
    coord_t             x;
    coord_t             y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_W-1:0]          s_axis_tdata  = '0;
  logic                     s_axis_tuser  = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_W-1:0]         m_axis_tdata;
  logic                     m_axis_tlast;
  logic                     psel          = 1'b0;
  logic                     penable       = 1'b0;
  logic                     pwrite        = 1'b0;
  logic [ADDR_W-1:0]        paddr         = '0;
  logic [DATA_W-1:0]        pwdata        = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // line walker mirror
  coord_t             walk_major = '0;
  coord_t             walk_minor = '0;
  coord_t             walk_end   = '0;
  logic signed [13:0] walk_err   = '0;
  coord_t             span_major = '0;
  coord_t             span_minor = '0;
  logic               walk_down  = 1'b0;
  logic               walk_steep = 1'b0;
  logic               walk_busy  = 1'b0;
  logic [COLOR_W-1:0] paint_color = bleng_pkg::COLOR_RESET;

  pixel_t      pixel_q[$];
  int unsigned fail_count   = 0;
  int unsigned reqs_sent    = 0;
  int unsigned quiet_cycles = 0;
  logic        src_gaps     = 1'b1;
  logic        sink_gaps    = 1'b1;
  logic        hold_ask     = 1'b0;
  logic        hold_seen    = 1'b0;
  int unsigned hold_left    = 0;

  bresenham_line_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic coord_t abs_gap(coord_t a, coord_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic coord_t near(coord_t base, int unsigned reach);
    int unsigned off;
    off = $urandom_range(reach);
    if ($urandom_range(1)) begin
      return (base + off > COORD_MAX) ? coord_t'(COORD_MAX) : coord_t'(base + off);
    end
    return (base < off) ? coord_t'(0) : coord_t'(base - off);
  endfunction

  function automatic int unsigned line_len(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    return ((abs_gap(xs, xe) > abs_gap(ys, ye)) ? abs_gap(xs, xe) : abs_gap(ys, ye)) + 1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (fail_count < PRINT_LIMIT) begin
      $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    end
    fail_count++;
  endtask

  task automatic predict_request(bleng_pkg::cmd_e cmd, coord_t xs, coord_t ys, coord_t xe,
                                 coord_t ye);
    coord_t             a0, b0, a1, b1, tmp;
    pixel_t             px;
    logic               at_end;
    logic signed [13:0] err_n;
    if (cmd == bleng_pkg::CMD_LOAD) begin
      walk_steep = abs_gap(ys, ye) > abs_gap(xs, xe);
      if (walk_steep) begin
        a0 = ys; b0 = xs; a1 = ye; b1 = xe;
      end else begin
        a0 = xs; b0 = ys; a1 = xe; b1 = ye;
      end
      if (a0 > a1) begin
        tmp = a0; a0 = a1; a1 = tmp;
        tmp = b0; b0 = b1; b1 = tmp;
      end
      span_major = a1 - a0;
      span_minor = abs_gap(b1, b0);
      walk_err   = $signed({3'b000, span_major[CW-1:1]});
      walk_down  = !(b0 < b1);
      walk_major = a0;
      walk_minor = b0;
      walk_end   = a1;
      walk_busy  = 1'b1;
    end else if (walk_busy) begin
      at_end   = walk_major == walk_end;
      px.x     = walk_steep ? walk_minor : walk_major;
      px.y     = walk_steep ? walk_major : walk_minor;
      px.color = paint_color;
      px.last  = at_end;
      pixel_q.push_back(px);
      err_n = walk_err - $signed({2'b00, span_minor});
      if (err_n < 0) begin
        walk_minor = walk_down ? walk_minor - 1'b1 : walk_minor + 1'b1;
        err_n      = err_n + $signed({2'b00, span_major});
      end
      walk_err   = err_n;
      walk_major = walk_major + 1'b1;
      if (at_end) begin
        walk_busy = 1'b0;
      end
    end
  endtask

  task automatic check_pixel();
    pixel_t want;
    if (pixel_q.size() == 0) begin
      report_mismatch("pixel with none pending", 32'(m_axis_tdata), '0);
    end else begin
      want = pixel_q.pop_front();
      if (m_axis_tdata[CW-1:0] != want.x) begin
        report_mismatch("pixel_x", 32'(m_axis_tdata[CW-1:0]), 32'(want.x));
      end
      if (m_axis_tdata[2*CW-1:CW] != want.y) begin
        report_mismatch("pixel_y", 32'(m_axis_tdata[2*CW-1:CW]), 32'(want.y));
      end
      if (m_axis_tdata[2*CW+COLOR_W-1:2*CW] != want.color) begin
        report_mismatch("pixel_color", 32'(m_axis_tdata[2*CW+COLOR_W-1:2*CW]),
                        32'(want.color));
      end
      if (m_axis_tlast != want.last) begin
        report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  endtask

  // outputs before inputs, both sampled before the edge updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_pixel();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_request(bleng_pkg::cmd_e'(s_axis_tuser), s_axis_tdata[CW-1:0],
                        s_axis_tdata[2*CW-1:CW], s_axis_tdata[3*CW-1:2*CW],
                        s_axis_tdata[4*CW-1:3*CW]);
      end
    end
  end

  // pixel sink with random stalls and a long hold on request
  always @(posedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !sink_gaps || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t watchdog: no progress for %0d cycles", $realtime, quiet_cycles);
      $display("** bresenham_line_engine: FAILED **");
      $finish;
    end
  end

  task automatic send_req(bleng_pkg::cmd_e cmd, coord_t xs, coord_t ys, coord_t xe,
                          coord_t ye);
    while (src_gaps && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {ye, xe, ys, xs};
    do @(posedge clk_i); while (!s_axis_tready);
    reqs_sent++;
  endtask

  task automatic send_steps(int unsigned count);
    repeat (count) begin
      send_req(bleng_pkg::CMD_STEP, coord_t'($urandom), coord_t'($urandom),
               coord_t'($urandom), coord_t'($urandom));
    end
  endtask

  task automatic draw_line(coord_t xs, coord_t ys, coord_t xe, coord_t ye, int unsigned steps);
    send_req(bleng_pkg::CMD_LOAD, xs, ys, xe, ye);
    send_steps(steps);
  endtask

  // stop sending and wait for every pending pixel, then for the pipe to empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(logic [ADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_color(logic [COLOR_W-1:0] color);
    logic [DATA_W-1:0] rd;
    apb_write(ADDR_DRAW_COLOR, DATA_W'(color));
    paint_color = color;
    apb_read(ADDR_DRAW_COLOR, rd);
    if (rd[COLOR_W-1:0] != color) begin
      report_mismatch("draw_color readback", rd, 32'(color));
    end
  endtask

  task automatic test_reset_state();
    logic [DATA_W-1:0] rd;
    apb_read(ADDR_DRAW_COLOR, rd);
    if (rd[COLOR_W-1:0] != bleng_pkg::COLOR_RESET) begin
      report_mismatch("draw_color after reset", rd, 32'(bleng_pkg::COLOR_RESET));
    end
    // steps before any line must produce nothing
    send_steps(3);
    settle();
  endtask

  task automatic test_line_shapes();
    draw_line('0, '0, '0, '0, 2);
    draw_line(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX),
              coord_t'(COORD_MAX), 1);
    draw_line(coord_t'(COORD_MAX), '0, coord_t'(COORD_MAX - 4), 12'd2, 5);
    draw_line('0, coord_t'(COORD_MAX), 12'd3, coord_t'(COORD_MAX - 4), 5);
    // diagonal abandoned halfway by a steep upward line
    draw_line(12'd10, 12'd10, 12'd13, 12'd13, 2);
    draw_line(12'd20, 12'd5, 12'd17, 12'd9, 5);
    settle();
  endtask

  task automatic test_colors();
    logic [COLOR_W-1:0] palette[5];
    coord_t             xs, ys, xe, ye;
    palette = '{16'h0000, 16'hFFFF, 16'hF800, COLOR_W'($urandom), COLOR_W'($urandom)};
    foreach (palette[i]) begin
      set_color(palette[i]);
      xs = coord_t'($urandom);
      ys = coord_t'($urandom);
      xe = near(xs, 6);
      ye = near(ys, 6);
      draw_line(xs, ys, xe, ye, line_len(xs, ys, xe, ye));
      settle();
    end
  endtask

  task automatic test_backpressure();
    src_gaps = 1'b0;
    send_req(bleng_pkg::CMD_LOAD, 12'd100, 12'd200, 12'd160, 12'd230);
    hold_ask <= !hold_ask;
    send_steps(61);
    settle();
    src_gaps = 1'b1;
  endtask

  task automatic test_random_lines();
    coord_t      xs, ys, xe, ye;
    int unsigned first, target, recolour_at, kind, steps, reach;
    first       = reqs_sent;
    target      = reqs_sent + RANDOM_REQS;
    recolour_at = reqs_sent + RECOLOUR_GAP;
    while (reqs_sent < target) begin
      if (reqs_sent >= recolour_at) begin
        settle();
        set_color(COLOR_W'($urandom));
        recolour_at += RECOLOUR_GAP;
      end
      // a long burst with no stalls on either side
      src_gaps = !(reqs_sent - first >= 500 && reqs_sent - first < 800);
      sink_gaps <= src_gaps;
      kind = $urandom_range(99);
      if (kind < 8) begin
        send_steps($urandom_range(1, 3));
      end else begin
        reach = (kind < 12) ? 300 : 12;
        xs    = coord_t'($urandom);
        ys    = coord_t'($urandom);
        xe    = near(xs, reach);
        ye    = near(ys, reach);
        steps = line_len(xs, ys, xe, ye);
        case ($urandom_range(9))
          0: steps = $urandom_range(steps - 1);
          1: steps = steps + $urandom_range(1, 2);
          default: ;
        endcase
        draw_line(xs, ys, xe, ye, steps);
      end
    end
    settle();
    src_gaps = 1'b1;
    sink_gaps <= 1'b1;
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_line_shapes();
    test_colors();
    test_backpressure();
    test_random_lines();
    set_color(bleng_pkg::COLOR_RESET);
    draw_line(12'd4000, 12'd50, 12'd4010, 12'd47, 11);
    settle();
    if (fail_count == 0) begin
      $display("** bresenham_line_engine: PASSED **");
    end else begin
      $display("** bresenham_line_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bleng_pkg.sv
src/bleng_front.sv
src/bleng_queue.sv
src/bleng_back.sv
src/bresenham_line_engine.sv
src/bleng_checker.sv
tb/tb_bresenham_line_engine.sv
